>>> src/ulcb_pkg.sv
// Package: shared types, constants and helpers for the LED command console.
`timescale 1ns / 1ps
package ulcb_pkg;

  localparam int unsigned LineCapacity = 64;
  localparam int unsigned LenW = $clog2(LineCapacity);
  localparam int unsigned PosW = $clog2(LineCapacity + 1);

  localparam logic [30:0] Max31 = 31'h7FFF_FFFF;
  localparam logic [30:0] DefaultPeriod = 31'd500;
  localparam logic [30:0] MinPeriod = 31'd10;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChDel = 8'h7F;

  typedef enum logic [2:0] {
    RespNone    = 3'd0,
    RespColor   = 3'd1,
    RespOff     = 3'd2,
    RespSteady  = 3'd3,
    RespBlink   = 3'd4,
    RespUnknown = 3'd5
  } resp_e;

  typedef enum logic [2:0] {
    ColOff   = 3'd0,
    ColRed   = 3'd1,
    ColGreen = 3'd2,
    ColBlue  = 3'd3,
    ColWhite = 3'd4
  } color_e;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StMatch,
    StSkip,
    StSign,
    StDigit,
    StFinish,
    StOut
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;       // latch input beat and do simple byte/tick work
    logic rd_start;   // issue a read at position 0
    logic rd_next;    // advance read position and issue read
    logic match_step; // compare read char against all command words
    logic sign_take;  // consume sign character
    logic digit_take; // accumulate digit
    logic finish;     // apply the line result
    logic out_load;   // load the output register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_eol;       // latched byte ends a nonempty line
    logic match_last;   // read position is last char needed for matching
    logic at_end;       // read position reached line length
    logic is_space;
    logic is_sign;
    logic is_digit;
    logic need_parse;   // blink chosen and line longer than six
  } stat_t;

  // Character of command word w at position i (0 beyond word end).
  function automatic logic [7:0] word_char(input logic [2:0] w, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (w)
      3'd0: case (i) 3'd0: c = "r"; 3'd1: c = "e"; 3'd2: c = "d"; default: c = 8'h00; endcase
      3'd1: case (i)
        3'd0: c = "g"; 3'd1: c = "r"; 3'd2: c = "e"; 3'd3: c = "e"; 3'd4: c = "n";
        default: c = 8'h00;
      endcase
      3'd2: case (i)
        3'd0: c = "b"; 3'd1: c = "l"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00;
      endcase
      3'd3: case (i)
        3'd0: c = "w"; 3'd1: c = "h"; 3'd2: c = "i"; 3'd3: c = "t"; 3'd4: c = "e";
        default: c = 8'h00;
      endcase
      3'd4: case (i) 3'd0: c = "o"; 3'd1: c = "f"; 3'd2: c = "f"; default: c = 8'h00; endcase
      3'd5: case (i)
        3'd0: c = "s"; 3'd1: c = "t"; 3'd2: c = "e"; 3'd3: c = "a"; 3'd4: c = "d";
        3'd5: c = "y"; default: c = 8'h00;
      endcase
      3'd6: case (i)
        3'd0: c = "b"; 3'd1: c = "l"; 3'd2: c = "i"; 3'd3: c = "n"; 3'd4: c = "k";
        default: c = 8'h00;
      endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] word_len(input logic [2:0] w);
    logic [2:0] n;
    case (w)
      3'd0, 3'd4: n = 3'd3;
      3'd2: n = 3'd4;
      3'd5: n = 3'd6;
      3'd1, 3'd3, 3'd6: n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] color_bits(input logic [2:0] c);
    logic [2:0] b;
    case (c)
      ColRed: b = 3'b100;
      ColGreen: b = 3'b010;
      ColBlue: b = 3'b001;
      ColWhite: b = 3'b111;
      default: b = 3'b000;
    endcase
    return b;
  endfunction

endpackage

>>> src/ulcb_if.sv
// Interfaces: input and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface ulcb_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  modport source (output valid, func, rx_byte, input ready);
  modport sink (input valid, func, rx_byte, output ready);
endinterface

interface ulcb_out_if;
  logic        valid;
  logic        ready;
  logic        echo_valid;
  logic [7:0]  echo_byte;
  logic        erase_echo;
  logic        line_done;
  logic [2:0]  response;
  logic [2:0]  response_color;
  logic [30:0] reported_delay;
  logic [2:0]  led_pins;
  modport source (output valid, echo_valid, echo_byte, erase_echo, line_done, response,
                  response_color, reported_delay, led_pins, input ready);
  modport sink (input valid, echo_valid, echo_byte, erase_echo, line_done, response,
                response_color, reported_delay, led_pins, output ready);
endinterface

>>> src/uart_led_command_blinker.sv
// Top level: LED command console with line editing and blink timer.
// A tick or plain byte is latched, then its result is loaded once the output is free.
// A line end is matched, then for blink its number is parsed (line up to 63 chars).
// One item at a time; the next item is accepted the cycle after its result is loaded.
// Reset: asynchronous active low; colour off, period 500, line empty; store unset.
`timescale 1ns / 1ps
module uart_led_command_blinker (
  input  logic       clk_i,
  input  logic       rst_ni,
  ulcb_in_if.sink    in_i,
  ulcb_out_if.source out_o
);

  ulcb_pkg::cmd_t  cmd;
  ulcb_pkg::stat_t stat;
  logic busy;

  ulcb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_busy_i (busy),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ulcb_datapath u_dp (
    .clk_i, .rst_ni,
    .in_func_i  (in_i.func),
    .in_byte_i  (in_i.rx_byte),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_busy_o (busy),
    .out_o      (out_o)
  );

endmodule

>>> src/ulcb_ctrl.sv
// Controller: sequences byte handling, line matching and number parsing.
`timescale 1ns / 1ps
module ulcb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_busy_i,
  input  ulcb_pkg::stat_t  stat_i,
  output ulcb_pkg::cmd_t   cmd_o
);

  ulcb_pkg::state_e state_q, state_d;

  // Hold state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ulcb_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ulcb_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = ulcb_pkg::StOut;
        end
      end
      ulcb_pkg::StOut: begin
        // entered right after take: decide line or direct output
        if (stat_i.is_eol) begin
          cmd_o.rd_start = 1'b1;
          state_d = ulcb_pkg::StMatch;
        end else if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d = ulcb_pkg::StIdle;
        end
      end
      ulcb_pkg::StMatch: begin
        cmd_o.match_step = 1'b1;
        if (stat_i.match_last) begin
          state_d = ulcb_pkg::StFinish;
          if (stat_i.need_parse) begin
            cmd_o.rd_next = 1'b1;
            state_d = ulcb_pkg::StSkip;
          end
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      ulcb_pkg::StSkip: begin
        if (stat_i.at_end) begin
          state_d = ulcb_pkg::StFinish;
        end else if (stat_i.is_space) begin
          cmd_o.rd_next = 1'b1;
        end else begin
          state_d = ulcb_pkg::StSign;
        end
      end
      ulcb_pkg::StSign: begin
        if (stat_i.is_sign) begin
          cmd_o.sign_take = 1'b1;
          cmd_o.rd_next = 1'b1;
        end
        state_d = ulcb_pkg::StDigit;
      end
      ulcb_pkg::StDigit: begin
        if (!stat_i.at_end && stat_i.is_digit) begin
          cmd_o.digit_take = 1'b1;
          cmd_o.rd_next = 1'b1;
        end else begin
          state_d = ulcb_pkg::StFinish;
        end
      end
      ulcb_pkg::StFinish: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d = ulcb_pkg::StIdle;
        end
      end
      default: state_d = ulcb_pkg::StIdle;
    endcase
  end

`ifndef SYNTHESIS
  // Input is only taken from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |-> state_q == ulcb_pkg::StIdle) else $error("take outside idle");
  // A result is never loaded while the previous one is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !out_busy_i) else $error("output overrun");
  // After a take the controller leaves idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> state_q != ulcb_pkg::StIdle) else $error("take did not start work");
`endif

endmodule

>>> src/ulcb_datapath.sv
// Datapath: line store, command matcher, decimal parser, LED timing, output register.
`timescale 1ns / 1ps
module ulcb_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_func_i,
  input  logic [7:0]      in_byte_i,
  input  ulcb_pkg::cmd_t  cmd_i,
  output ulcb_pkg::stat_t stat_o,
  output logic            out_busy_o,
  ulcb_out_if.source      out_o
);

  localparam int unsigned LenW = ulcb_pkg::LenW;
  localparam int unsigned PosW = ulcb_pkg::PosW;

  logic [7:0] mem_q [ulcb_pkg::LineCapacity];
  logic [7:0] rd_q;
  logic [LenW-1:0] len_q;
  logic [PosW-1:0] pos_q; // position of char currently in rd_q
  logic [PosW-1:0] rd_addr;
  logic func_q;
  logic [7:0] byte_q;
  logic erase_q;
  logic [6:0] alive_q, alive_d; // per-command match still possible
  logic neg_q;
  logic [31:0] acc_q; // saturates at 2^31
  logic [2:0] color_q;
  logic blink_q;
  logic [30:0] period_q;
  logic [30:0] elapsed_q;
  logic phase_q;
  logic [2:0] led_q;
  logic ovalid_q;
  logic [2:0] resp;
  logic [30:0] delay;
  logic [2:0] color_n;
  logic blink_n;
  logic [30:0] period_n;
  logic [30:0] parsed;
  logic is_lf;
  logic is_bs;
  logic [PosW-1:0] len_ext;
  logic [2:0] win;
  logic [2:0] win_d;
  logic [35:0] acc_x10;

  assign len_ext = PosW'(len_q);
  assign is_lf = (byte_q == ulcb_pkg::ChCr) || (byte_q == ulcb_pkg::ChLf);
  assign is_bs = (byte_q == ulcb_pkg::ChBs) || (byte_q == ulcb_pkg::ChDel);
  assign rd_addr = cmd_i.rd_start ? '0 : pos_q + PosW'(1);

  // Write and read the line store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !in_func_i && !(in_byte_i == ulcb_pkg::ChCr ||
        in_byte_i == ulcb_pkg::ChLf || in_byte_i == ulcb_pkg::ChBs ||
        in_byte_i == ulcb_pkg::ChDel) && len_q != LenW'(ulcb_pkg::LineCapacity - 1)) begin
      mem_q[len_q] <= in_byte_i;
    end
    if (cmd_i.rd_start || cmd_i.rd_next) begin
      rd_q <= mem_q[rd_addr[LenW-1:0]];
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o.is_eol = !func_q && is_lf && len_q != '0;
    stat_o.match_last = (pos_q == PosW'(5)) || (pos_q + PosW'(1) == len_ext);
    stat_o.at_end = pos_q >= len_ext;
    stat_o.is_space = rd_q == 8'h20 || rd_q == 8'h09 || rd_q == 8'h0B || rd_q == 8'h0C;
    stat_o.is_sign = rd_q == 8'h2B || rd_q == 8'h2D;
    stat_o.is_digit = rd_q >= 8'h30 && rd_q <= 8'h39;
    stat_o.need_parse = (win_d == 3'd6) && (len_ext > PosW'(6));
  end

  // Narrow match vector after this char.
  always_comb begin
    alive_d = alive_q;
    for (int w = 0; w < 7; w++) begin
      if (pos_q < PosW'(ulcb_pkg::word_len(3'(w))) &&
          rd_q != ulcb_pkg::word_char(3'(w), pos_q[2:0])) begin
        alive_d[w] = 1'b0;
      end
    end
  end

  // Pick the first matching command from the vector after this char.
  always_comb begin
    win_d = 3'd7;
    for (int w = 6; w >= 0; w--) begin
      if (alive_d[w] && len_ext >= PosW'(ulcb_pkg::word_len(3'(w)))) win_d = 3'(w);
    end
  end

  // Pick the first matching command from the final vector.
  always_comb begin
    win = 3'd7;
    for (int w = 6; w >= 0; w--) begin
      if (alive_q[w] && len_ext >= PosW'(ulcb_pkg::word_len(3'(w)))) win = 3'(w);
    end
  end

  assign acc_x10 = {4'd0, acc_q} * 36'd10 + 36'(rd_q - 8'h30);

  // Resolve parsed period.
  always_comb begin
    if (len_ext <= PosW'(6)) parsed = ulcb_pkg::DefaultPeriod;
    else if (neg_q) parsed = ulcb_pkg::MinPeriod;
    else if (acc_q > 32'(ulcb_pkg::Max31)) parsed = ulcb_pkg::Max31;
    else if (acc_q < 32'(ulcb_pkg::MinPeriod)) parsed = ulcb_pkg::MinPeriod;
    else parsed = acc_q[30:0];
  end

  // Line result.
  always_comb begin
    resp = ulcb_pkg::RespNone;
    delay = '0;
    color_n = color_q;
    blink_n = blink_q;
    period_n = period_q;
    if (!func_q && is_lf && len_q != '0) begin
      case (win)
        3'd0: begin color_n = ulcb_pkg::ColRed; resp = ulcb_pkg::RespColor; end
        3'd1: begin color_n = ulcb_pkg::ColGreen; resp = ulcb_pkg::RespColor; end
        3'd2: begin color_n = ulcb_pkg::ColBlue; resp = ulcb_pkg::RespColor; end
        3'd3: begin color_n = ulcb_pkg::ColWhite; resp = ulcb_pkg::RespColor; end
        3'd4: begin color_n = ulcb_pkg::ColOff; blink_n = 1'b0; resp = ulcb_pkg::RespOff; end
        3'd5: begin blink_n = 1'b0; resp = ulcb_pkg::RespSteady; end
        3'd6: begin
          blink_n = 1'b1; period_n = parsed; delay = parsed; resp = ulcb_pkg::RespBlink;
        end
        default: resp = ulcb_pkg::RespUnknown;
      endcase
    end
  end

  // Sequence registers for byte, match and parse, plus colour, blink timing and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pos_q <= '0;
      func_q <= 1'b1;
      byte_q <= '0;
      erase_q <= 1'b0;
      alive_q <= '1;
      neg_q <= 1'b0;
      acc_q <= '0;
      color_q <= ulcb_pkg::ColOff;
      blink_q <= 1'b0;
      period_q <= ulcb_pkg::DefaultPeriod;
      elapsed_q <= '0;
      phase_q <= 1'b0;
      led_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        func_q <= in_func_i;
        byte_q <= in_byte_i;
        erase_q <= 1'b0;
        alive_q <= '1;
        neg_q <= 1'b0;
        acc_q <= '0;
        if (in_func_i) begin
          if (elapsed_q != ulcb_pkg::Max31) elapsed_q <= elapsed_q + 31'd1;
        end else if (in_byte_i == ulcb_pkg::ChBs || in_byte_i == ulcb_pkg::ChDel) begin
          if (len_q != '0) begin
            len_q <= len_q - LenW'(1);
            erase_q <= 1'b1;
          end
        end else if (!(in_byte_i == ulcb_pkg::ChCr || in_byte_i == ulcb_pkg::ChLf) &&
                     len_q != LenW'(ulcb_pkg::LineCapacity - 1)) begin
          len_q <= len_q + LenW'(1);
        end
      end
      if (cmd_i.rd_start) pos_q <= '0;
      else if (cmd_i.rd_next) pos_q <= pos_q + PosW'(1);
      if (cmd_i.match_step) alive_q <= alive_d;
      if (cmd_i.sign_take) neg_q <= rd_q == 8'h2D;
      if (cmd_i.digit_take) begin
        acc_q <= (acc_x10 > 36'(ulcb_pkg::Max31)) ? 32'h8000_0000 : acc_x10[31:0];
      end
      if (cmd_i.finish) begin
        color_q <= color_n;
        blink_q <= blink_n;
        period_q <= period_n;
        if (!func_q && is_lf) len_q <= '0;
      end
      // Refresh LEDs when a result is loaded.
      if (cmd_i.out_load) begin
        if (blink_n && color_n != ulcb_pkg::ColOff) begin
          if (elapsed_q >= period_n) begin
            elapsed_q <= '0;
            phase_q <= !phase_q;
            led_q <= !phase_q ? ulcb_pkg::color_bits(color_n) : 3'b000;
          end
        end else begin
          led_q <= ulcb_pkg::color_bits(color_n);
        end
      end
      if (cmd_i.out_load) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_o.echo_valid <= !func_q;
      out_o.echo_byte <= func_q ? 8'h00 : byte_q;
      out_o.erase_echo <= erase_q;
      out_o.line_done <= !func_q && is_lf;
      out_o.response <= resp;
      out_o.response_color <= color_n;
      out_o.reported_delay <= delay;
    end
  end

  assign out_o.led_pins = led_q;
  assign out_o.valid = ovalid_q;
  assign out_busy_o = ovalid_q && !out_o.ready;

`ifndef SYNTHESIS
  // A tick beat leaves the stored line untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && in_func_i) |=> $stable(len_q)) else $error("tick changed line");
  // A finished line clears the stored length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && !func_q && is_lf) |=> len_q == '0) else $error("line not cleared");
  // Output appears right after a load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> ovalid_q) else $error("lost result");
`endif

endmodule
